FILE: rtl/core/dci_pkg.sv
package dci_pkg;

   localparam int MAX_ROWS_DEF = 32;
   localparam int SPAN_LIMIT = 8;
   localparam int DEPTH_W = 16;
   localparam int ROW_W = 6;
   localparam int SPAN_W = 4;
   localparam int SUM_W = 24;
   localparam int CNT_W = 8;
   localparam int FIFO_DEPTH = 4;

   localparam logic CSR_SPAN = 1'b0;
   localparam logic CSR_THRESH = 1'b1;

   typedef struct packed {
      logic [15:0] depth_in;
      logic        end_of_column;
   } req_word_type;

   typedef struct packed {
      logic [15:0] depth_out;
      logic [5:0]  row_index;
      logic        last_of_column;
   } rsp_word_type;

   // Word handed from the front to the back through the queue.
   typedef struct packed {
      logic [15:0] depth;
      logic        last;
      logic        keep;
   } entry_type;

endpackage

FILE: rtl/core/dci_front.sv
module dci_front
   import dci_pkg::*;
#(
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   input  logic         q_stall,
   output logic         q_valid,
   output entry_type    q_word
);

   localparam int CW = $clog2(MAX_ROWS + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          acc;

   // Rows beyond the store are marked so the back drops them.
   assign req_stall = q_stall;
   assign q_valid   = req_valid;
   assign acc       = req_valid && !q_stall;
   always_comb begin
      q_word.depth = req_word.depth_in;
      q_word.last  = req_word.end_of_column;
      q_word.keep  = (count_ff < CW'(MAX_ROWS));
      count_in     = count_ff;
      if (acc) begin
         if (req_word.end_of_column) count_in = '0;
         else if (q_word.keep) count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else count_ff <= count_in;
   end

endmodule

FILE: rtl/core/dci_queue.sv
module dci_queue
   import dci_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_stall,
   input  entry_type in_word,
   output logic      out_valid,
   input  logic      out_take,
   output entry_type out_word
);

   localparam int AW = $clog2(FIFO_DEPTH);

   entry_type     slots_ff [FIFO_DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   fill_ff, fill_in;
   logic          push, pop;

   assign in_stall  = (fill_ff == (AW+1)'(FIFO_DEPTH));
   assign out_valid = (fill_ff != '0);
   assign out_word  = slots_ff[rp_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_take && out_valid;
   always_comb fill_in = fill_ff + (AW+1)'(push) - (AW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slots_ff[wp_ff] <= in_word;
   end

endmodule

FILE: rtl/core/dci_back.sv
module dci_back
   import dci_pkg::*;
#(
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_take,
   input  entry_type         q_word,
   input  logic [SPAN_W-1:0] span_cfg,
   input  logic [15:0]       thresh_cfg,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_word_type      rsp_word
);

   localparam int AW = $clog2(MAX_ROWS);
   localparam int CW = $clog2(MAX_ROWS + 1);

   localparam logic [2:0] ST_LOAD = 3'd0;
   localparam logic [2:0] ST_ROW  = 3'd1;
   localparam logic [2:0] ST_UP   = 3'd2;
   localparam logic [2:0] ST_DN   = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;
   localparam logic [2:0] ST_OWT  = 3'd6;

   logic [15:0]   mem [MAX_ROWS];
   logic [15:0]   rd_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [15:0]   wr_data;

   logic [2:0]    st_ff, st_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] r_ff, r_in;
   logic [3:0]    i_ff, i_in, j_ff, j_in;
   logic [3:0]    span_ff, span_in;
   logic [15:0]   up_ff, up_in;
   logic          pend_ff, pend_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0] quo_ff, quo_in, rem_ff, rem_in;
   logic [4:0]    dstep_ff, dstep_in;
   logic          ov_ff, ov_in;
   rsp_word_type  ow_ff, ow_in;

   logic [3:0]    i_nxt, j_nxt;
   logic [CW:0]   up_one, up_nxt, dn_one, dn_nxt;
   logic [16:0]   gap;
   logic [SUM_W:0] trial;

   // Neighbour rows are formed from the registered offsets only.
   always_comb begin
      gap = (up_ff > rd_ff) ? {1'b0, up_ff - rd_ff} : {1'b0, rd_ff - up_ff};
      i_nxt = i_ff + 1'b1;
      j_nxt = j_ff + 1'b1;
      up_one = {1'b0, r_ff} - (CW+1)'(1);
      up_nxt = {1'b0, r_ff} - (CW+1)'(i_nxt);
      dn_one = {1'b0, r_ff} + (CW+1)'(1);
      dn_nxt = {1'b0, r_ff} + (CW+1)'(j_nxt);
      trial = {1'b0, rem_ff[SUM_W-2:0], quo_ff[SUM_W-1]};
   end

   always_comb begin
      st_in = st_ff; n_in = n_ff; r_in = r_ff; i_in = i_ff; j_in = j_ff;
      span_in = span_ff; up_in = up_ff; pend_in = 1'b0; sum_in = sum_ff;
      cnt_in = cnt_ff; quo_in = quo_ff; rem_in = rem_ff; dstep_in = dstep_ff;
      ov_in = ov_ff; ow_in = ow_ff;
      q_take = 1'b0; wr_en = 1'b0; wr_addr = r_ff[AW-1:0]; wr_data = q_word.depth;
      rd_addr = r_ff[AW-1:0];
      if (ov_ff && !rsp_stall) ov_in = 1'b0;
      unique case (st_ff)
         ST_LOAD: begin
            q_take = 1'b1;
            if (q_valid) begin
               if (q_word.keep) begin
                  wr_en = 1'b1;
                  wr_addr = n_ff[AW-1:0];
               end
               n_in = n_ff + CW'(q_word.keep);
               if (q_word.last) begin
                  st_in = ST_ROW;
                  r_in = '0;
                  span_in = (span_cfg > 4'(SPAN_LIMIT)) ? 4'(SPAN_LIMIT) : span_cfg;
               end
            end
         end
         ST_ROW: begin
            // rd_ff holds the row itself in the next cycle
            if (!pend_ff) begin
               pend_in = 1'b1;
               rd_addr = r_ff[AW-1:0];
            end else if (rd_ff != 16'd0) begin
               st_in = ST_OUT;
            end else begin
               sum_in = '0; cnt_in = '0; i_in = 4'd1;
               if (span_ff < 4'd2 || r_ff == '0) st_in = ST_DIV;
               else begin
                  st_in = ST_UP;
                  rd_addr = up_one[AW-1:0];
               end
            end
         end
         ST_UP: begin
            up_in = rd_ff;
            j_in = 4'd1;
            st_in = ST_DN;
            if (dn_one >= (CW+1)'(n_ff) || rd_ff == 16'd0) begin
               // no lower neighbour or empty upper: next offset
               i_in = i_nxt;
               if (i_nxt >= span_ff || (CW+1)'(i_nxt) > (CW+1)'(r_ff)) st_in = ST_DIV;
               else st_in = ST_UP;
               rd_addr = up_nxt[AW-1:0];
            end else rd_addr = dn_one[AW-1:0];
         end
         ST_DN: begin
            if (rd_ff != 16'd0 && gap < {1'b0, thresh_cfg}) begin
               sum_in = sum_ff + SUM_W'(up_ff) + SUM_W'(rd_ff);
               cnt_in = cnt_ff + CNT_W'(2);
            end
            j_in = j_nxt;
            if (j_nxt < span_ff && dn_nxt < (CW+1)'(n_ff)) begin
               rd_addr = dn_nxt[AW-1:0];
            end else begin
               i_in = i_nxt;
               if (i_nxt >= span_ff || (CW+1)'(i_nxt) > (CW+1)'(r_ff)) st_in = ST_DIV;
               else begin
                  st_in = ST_UP;
                  rd_addr = up_nxt[AW-1:0];
               end
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit a cycle
            if (cnt_ff == '0) begin
               st_in = ST_OUT;
            end else if (dstep_ff == '0) begin
               quo_in = sum_ff; rem_in = '0;
               dstep_in = 5'd1;
            end else begin
               quo_in = {quo_ff[SUM_W-2:0], 1'b0};
               rem_in = trial[SUM_W-1:0];
               if (trial >= (SUM_W+1)'(cnt_ff)) begin
                  rem_in = trial[SUM_W-1:0] - SUM_W'(cnt_ff);
                  quo_in[0] = 1'b1;
               end
               dstep_in = dstep_ff + 1'b1;
               if (dstep_ff == 5'(SUM_W)) begin
                  dstep_in = '0;
                  wr_en = 1'b1;
                  wr_addr = r_ff[AW-1:0];
                  wr_data = quo_in[15:0];
                  st_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            rd_addr = r_ff[AW-1:0];
            st_in = ST_OWT;
         end
         ST_OWT: begin
            if (!ov_ff || !rsp_stall) begin
               ov_in = 1'b1;
               ow_in.depth_out = rd_ff;
               ow_in.row_index = 6'(r_ff);
               ow_in.last_of_column = (r_ff + 1'b1 == n_ff);
               r_in = r_ff + 1'b1;
               if (r_in == n_ff) begin
                  st_in = ST_LOAD;
                  n_in = '0;
               end else st_in = ST_ROW;
            end
         end
         default: st_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_LOAD; n_ff <= '0; ov_ff <= 1'b0; pend_ff <= 1'b0;
         dstep_ff <= '0; r_ff <= '0;
      end else begin
         st_ff <= st_in; n_ff <= n_in; ov_ff <= ov_in; pend_ff <= pend_in;
         dstep_ff <= dstep_in; r_ff <= r_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in; j_ff <= j_in; span_ff <= span_in; up_ff <= up_in;
      sum_ff <= sum_in; cnt_ff <= cnt_in; quo_ff <= quo_in; rem_ff <= rem_in;
      ow_ff <= ow_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_word  = ow_ff;

   a_take_load: assert property (@(posedge clock) disable iff (reset)
      q_take |-> st_ff == ST_LOAD) else $error("queue read outside load");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && rsp_stall) |=> ov_ff && $stable(ow_ff)) else $error("result lost");
   a_rows: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CW'(MAX_ROWS)) else $error("row count overflow");

endmodule

FILE: rtl/core/depth_column_inpaint.sv
// A column is emitted after its flagged word; an empty row takes longer than a
// nonzero row, its time set by the shared store read port and the bit-serial divider.
// Input words are written to the store while the back is in its load state.
// Throughput: one column at a time; input continues into the queue until it is full.
// Reset: synchronous, active high; clears control and restores span 5, threshold 256.
module depth_column_inpaint
   import dci_pkg::*;
#(
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [15:0]  csr_data
);

   logic [SPAN_W-1:0] span_ff;
   logic [15:0]       thresh_ff;
   logic              fq_valid, fq_stall, bq_valid, bq_take;
   entry_type         fq_word, bq_word;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff <= SPAN_W'(5);
         thresh_ff <= 16'd256;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SPAN:   span_ff <= csr_data[SPAN_W-1:0];
            CSR_THRESH: thresh_ff <= csr_data;
            default: ;
         endcase
      end
   end

   dci_front #(.MAX_ROWS(MAX_ROWS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_word,
      .q_stall(fq_stall), .q_valid(fq_valid), .q_word(fq_word));

   dci_queue u_queue (
      .clock, .reset, .in_valid(fq_valid), .in_stall(fq_stall), .in_word(fq_word),
      .out_valid(bq_valid), .out_take(bq_take), .out_word(bq_word));

   dci_back #(.MAX_ROWS(MAX_ROWS)) u_back (
      .clock, .reset, .q_valid(bq_valid), .q_take(bq_take), .q_word(bq_word),
      .span_cfg(span_ff), .thresh_cfg(thresh_ff),
      .rsp_valid, .rsp_stall, .rsp_word);

endmodule
